[sv/tfp_pkg.sv]
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the touch frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PRESS_W    = 12;
  localparam int unsigned STORE_LEN  = 5;
  localparam int unsigned COUNT_W    = 3;

  localparam logic [BYTE_W-1:0]  HDR_A         = 8'h61;
  localparam logic [BYTE_W-1:0]  HDR_B         = 8'hA1;
  localparam logic [BYTE_W-1:0]  HDR_REL       = 8'hE1;
  localparam logic [PRESS_W-1:0] FULL_PRESSURE = 12'hFFF;
  localparam logic [COUNT_W-1:0] LAST_COUNT    = COUNT_W'(STORE_LEN);

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_EMPTY = 2'd1,
    OP_TICK  = 2'd2
  } tfp_op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ERROR   = 2'd2
  } tfp_kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
    logic [PRESS_W-1:0] pressure;
  } tfp_result_t;

  function automatic logic is_header(input logic [BYTE_W-1:0] b);
    return (b == HDR_A) || (b == HDR_B) || (b == HDR_REL);
  endfunction

endpackage

[sv/tfp_in_if.sv]
// ----------------------------------------------------------------------------
// tfp_in_if
// Input request channel: event opcode and received serial byte.
// ----------------------------------------------------------------------------
interface tfp_in_if import tfp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

[sv/tfp_out_if.sv]
// ----------------------------------------------------------------------------
// tfp_out_if
// Result request channel: touch report fields.
// ----------------------------------------------------------------------------
interface tfp_out_if import tfp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  report_kind;
  logic [POS_W-1:0]   x_pos;
  logic [POS_W-1:0]   y_pos;
  logic [PRESS_W-1:0] pressure;

  modport source (output valid, output report_kind, output x_pos, output y_pos,
                  output pressure, input ready);
  modport sink   (input valid, input report_kind, input x_pos, input y_pos,
                  input pressure, output ready);
endinterface

[sv/tfp_core.sv]
// ----------------------------------------------------------------------------
// tfp_core
// Frame state (byte count, stored bytes, pressed flag) and per-event decode.
// ----------------------------------------------------------------------------
module tfp_core import tfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [OP_W-1:0]   op,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output tfp_result_t       res
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               pressed_r, pressed_nxt;
  logic [BYTE_W-1:0]  store_r [STORE_LEN];
  logic               wr_en;
  logic [BYTE_W-1:0]  sum;

  assign sum = store_r[0] + store_r[1] + store_r[2] + store_r[3] + store_r[4];

  always_comb begin
    count_nxt   = count_r;
    pressed_nxt = pressed_r;
    wr_en       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (step) begin
      case (tfp_op_t'(op))
        OP_EMPTY: begin
          count_nxt = '0;
        end
        OP_TICK: begin
          if (pressed_r) begin
            pressed_nxt = 1'b0;
            res_valid   = 1'b1;
            res.kind    = KIND_RELEASE;
          end
        end
        OP_BYTE: begin
          if ((count_r == '0) && !is_header(rx_byte)) begin
            count_nxt = '0;
          end else if (count_r < LAST_COUNT) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = '0;
            res_valid = 1'b1;
            if (rx_byte != ~sum) begin
              res.kind = KIND_ERROR;
            end else if (store_r[0] == HDR_REL) begin
              res.kind = KIND_RELEASE;
            end else begin
              // header is 0x61 or 0xA1 here
              pressed_nxt  = 1'b1;
              res.kind     = KIND_PRESS;
              res.x_pos    = {store_r[2], store_r[1]};
              res.y_pos    = {store_r[4], store_r[3]};
              res.pressure = FULL_PRESSURE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      pressed_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      pressed_r <= pressed_nxt;
    end
  end

  // every full frame rewrites all five entries after the last clear
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r] <= rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_COUNT) else $error("byte count out of range");

  a_press_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == KIND_PRESS) |=> pressed_r)
    else $error("press report did not set flag");

  a_tick_release: assert property (@(posedge clk) disable iff (!rst_n)
    step && (op == OP_TICK) && pressed_r |=> !pressed_r)
    else $error("timeout did not clear flag");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (op == OP_BYTE) && (count_r == LAST_COUNT) |=> (count_r == '0))
    else $error("frame not cleared after sixth byte");

  a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> step) else $error("result without event");

endmodule

[sv/touch_frame_parser.sv]
// ----------------------------------------------------------------------------
// touch_frame_parser
// Builds six-byte touch frames from a serial byte stream and emits reports.
// ----------------------------------------------------------------------------
// Input channel in_ch carries one event per request: a received byte, an
// empty read (drops a partial frame) or a timeout tick (releases once if a
// press is held). Output channel out_ch carries press, release or checksum
// error reports; each event yields zero or one report.
// Timing: an event is registered at the input, decoded from the input
// register and its report is loaded into the output register once out_ch
// is not stalled, and out_ch.valid is driven from that register. Throughput
// is one event per cycle while out_ch does not stall, set by the single
// decode stage between the input and output registers.
// When out_ch stalls with a report waiting, one more event is held in the
// input register and in_ch.ready drops until the report is taken.
// Reset clears the byte count, the pressed flag and both valid registers;
// the block takes events from the first cycle after reset.
// ----------------------------------------------------------------------------
module touch_frame_parser import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tfp_in_if.sink    in_ch,
  tfp_out_if.source out_ch
);

  logic              in_valid_r, in_valid_nxt;
  logic [OP_W-1:0]   in_op_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  tfp_result_t       out_res_r;
  logic              adv;
  logic              step;
  logic              res_valid;
  tfp_result_t       res;

  assign adv          = !out_valid_r || out_ch.ready;
  assign step         = in_valid_r && adv;
  assign in_ch.ready  = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.ready) begin
      in_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_op_r   <= in_ch.opcode;
      in_byte_r <= in_ch.rx_byte;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  tfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .op        (in_op_r),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.report_kind = out_res_r.kind;
  assign out_ch.x_pos       = out_res_r.x_pos;
  assign out_ch.y_pos       = out_res_r.y_pos;
  assign out_ch.pressure    = out_res_r.pressure;

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_op_r) && $stable(in_byte_r))
    else $error("held event lost while output stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !step)
    else $error("decode advanced over a waiting report");

  a_report_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step && res_valid))
    else $error("report appeared without a decoded event");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives touch_frame_parser with byte, empty-read and timeout requests. A
// scoreboard tracks the frame state, predicts each report and compares it
// field by field against the output channel. Directed frames are followed by
// random frames and noise, under four sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned     QUIET_LIMIT = 1000;
  localparam int unsigned     PHASE_ITEMS = 110;

  class touch_scoreboard;
    logic [COUNT_W-1:0] byte_cnt;
    logic [BYTE_W-1:0]  frame_bytes [STORE_LEN];
    logic               held;
    tfp_result_t        pending_reports [$];
    int                 errors;

    function new();
      clear_frame();
      held   = 1'b0;
      errors = 0;
    endfunction

    function void clear_frame();
      byte_cnt = '0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function bit predict_report(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                                output tfp_result_t r);
      logic [BYTE_W-1:0] sum;
      r = '0;
      case (op)
        OP_EMPTY: begin
          clear_frame();
          return 1'b0;
        end
        OP_TICK: begin
          if (!held) return 1'b0;
          held   = 1'b0;
          r.kind = KIND_RELEASE;
          return 1'b1;
        end
        OP_BYTE: begin
          if (byte_cnt == '0 && b != HDR_A && b != HDR_B && b != HDR_REL) begin
            clear_frame();
            return 1'b0;
          end
          if (byte_cnt < LAST_COUNT) begin
            frame_bytes[byte_cnt] = b;
            byte_cnt = byte_cnt + 1'b1;
            return 1'b0;
          end
          sum = '0;
          foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
          sum = ~sum;
          if (b != sum) begin
            r.kind = KIND_ERROR;
          end else if (frame_bytes[0] == HDR_REL) begin
            r.kind = KIND_RELEASE;
          end else begin
            r.kind     = KIND_PRESS;
            r.x_pos    = {frame_bytes[2], frame_bytes[1]};
            r.y_pos    = {frame_bytes[4], frame_bytes[3]};
            r.pressure = FULL_PRESSURE;
            held       = 1'b1;
          end
          clear_frame();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
      tfp_result_t r;
      if (predict_report(op, b, r)) pending_reports.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_report(tfp_result_t got);
      tfp_result_t exp_r;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report kind %0d", got.kind));
        return;
      end
      exp_r = pending_reports.pop_front();
      if (got.kind != exp_r.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
      if (got.x_pos != exp_r.x_pos)
        report_mismatch($sformatf("x_pos %h, want %h", got.x_pos, exp_r.x_pos));
      if (got.y_pos != exp_r.y_pos)
        report_mismatch($sformatf("y_pos %h, want %h", got.y_pos, exp_r.y_pos));
      if (got.pressure != exp_r.pressure)
        report_mismatch($sformatf("pressure %h, want %h", got.pressure, exp_r.pressure));
    endtask
  endclass

  logic clk;
  logic rst_n;

  tfp_in_if  in_ch();
  tfp_out_if out_ch();

  touch_frame_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  touch_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int item_count    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, b);
    if (op != OP_UNUSED) item_count++;
  endtask

  // corrupt != 0 flips checksum bits
  task automatic send_frame(logic [BYTE_W-1:0] hdr, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [BYTE_W-1:0] corrupt);
    logic [BYTE_W-1:0] body [STORE_LEN];
    logic [BYTE_W-1:0] sum;
    body = '{hdr, x[7:0], x[15:8], y[7:0], y[15:8]};
    sum  = '0;
    foreach (body[i]) begin
      sum = sum + body[i];
      send_request(OP_BYTE, body[i]);
    end
    send_request(OP_BYTE, ~sum ^ corrupt);
  endtask

  function automatic logic [BYTE_W-1:0] random_header();
    case ($urandom_range(2))
      0:       return HDR_A;
      1:       return HDR_B;
      default: return HDR_REL;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_report('{out_ch.report_kind, out_ch.x_pos, out_ch.y_pos, out_ch.pressure});
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    static int idle_mix  [4] = '{0, 65, 0, 36};
    static int stall_mix [4] = '{0, 0, 65, 36};
    int goal;
    int k;
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_BYTE;
    in_ch.rx_byte <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_request(OP_TICK, 8'h00);
    send_frame(HDR_A, 16'h0000, 16'hFFFF, 8'h00);
    send_request(OP_TICK, 8'hFF);
    send_frame(HDR_B, 16'hFFFF, 16'h0000, 8'h01);
    send_frame(HDR_REL, 16'h1234, 16'hABCD, 8'h00);
    send_request(OP_BYTE, 8'hFF);
    send_request(OP_BYTE, HDR_REL);
    send_request(OP_EMPTY, 8'h00);
    send_request(OP_UNUSED, 8'hA5);

    foreach (idle_mix[p]) begin
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      goal          = item_count + PHASE_ITEMS;
      while (item_count < goal) begin
        k = $urandom_range(99);
        if (k < 70) begin
          send_frame(random_header(), 16'($urandom), 16'($urandom),
                     ($urandom_range(99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00);
        end else if (k < 80) begin
          // truncated frame, dropped by an empty read
          send_request(OP_BYTE, random_header());
          repeat ($urandom_range(0, 4)) send_request(OP_BYTE, 8'($urandom));
          send_request(OP_EMPTY, 8'($urandom));
        end else if (k < 90) begin
          send_request(OP_BYTE, 8'($urandom));
        end else if (k < 95) begin
          send_request(OP_TICK, 8'($urandom));
        end else if (k < 98) begin
          send_request(OP_EMPTY, 8'($urandom));
        end else begin
          send_request(OP_UNUSED, 8'($urandom));
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
sv/tfp_pkg.sv
sv/tfp_in_if.sv
sv/tfp_out_if.sv
sv/tfp_core.sv
sv/touch_frame_parser.sv
bench/tb_top.sv
